FILE: rtl/mmp_pkg.sv
package mmp_pkg;

    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    localparam int VAL_W  = 32;
    localparam int ROW_W  = 3;
    localparam int DIM_W  = 4;
    localparam int FUNC_W = 2;
    localparam int CFG_W  = 2;

    // Matrix slots held in every cell: the two loaded stores and four work buffers.
    localparam int NUM_SLOTS = 6;
    localparam int NUM_WORK  = 4;
    localparam int SLOT_W    = 3;
    localparam logic [SLOT_W-1:0] SLOT_A     = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_B     = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_WORK0 = 3'd2;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUL    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_POW    = 2'd3;

    localparam logic [CFG_W-1:0] CFG_A_ROWS = 2'd0;
    localparam logic [CFG_W-1:0] CFG_A_COLS = 2'd1;
    localparam logic [CFG_W-1:0] CFG_B_ROWS = 2'd2;
    localparam logic [CFG_W-1:0] CFG_B_COLS = 2'd3;

    // One element position travelling down the chain.
    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic             last;
    } t_tag;

    // Operand sources and destination of one pass over a result matrix.
    typedef struct packed {
        logic              x_diag;
        logic [SLOT_W-1:0] x_slot;
        logic [VAL_W-1:0]  x_val;
        logic              y_diag;
        logic [SLOT_W-1:0] y_slot;
        logic [VAL_W-1:0]  y_val;
        logic [DIM_W-1:0]  inner;
        logic              emit;
        logic [SLOT_W-1:0] dest;
    } t_pass;

    // Element write broadcast to all cells.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [VAL_W-1:0]  data;
    } t_wr;

endpackage

FILE: rtl/mmp_in_if.sv
interface mmp_in_if;
    logic                              valid;
    logic                              ready;
    logic [mmp_pkg::FUNC_W-1:0]        func;
    logic [mmp_pkg::ROW_W-1:0]         row;
    logic [mmp_pkg::ROW_W-1:0]         col;
    logic signed [mmp_pkg::VAL_W-1:0]  value;
    logic signed [mmp_pkg::VAL_W-1:0]  degree;

    modport source (output valid, func, row, col, value, degree, input ready);
    modport sink   (input valid, func, row, col, value, degree, output ready);
endinterface

FILE: rtl/mmp_out_if.sv
interface mmp_out_if;
    logic                              valid;
    logic                              ready;
    logic [mmp_pkg::ROW_W-1:0]         out_row;
    logic [mmp_pkg::ROW_W-1:0]         out_col;
    logic signed [mmp_pkg::VAL_W-1:0]  out_value;
    logic                              last;
    logic                              error;

    modport source (output valid, out_row, out_col, out_value, last, error, input ready);
    modport sink   (input valid, out_row, out_col, out_value, last, error, output ready);
endinterface

FILE: rtl/matrix_multiply_power.sv
// Loads take one request per cycle while the engine is idle, and give no result.
// Multiply: one pass of R*C elements, streamed one element per cycle while the sink
// takes them; the next request is taken once the pass has drained from the chain.
// Power: one pass per squaring, one per set exponent bit after the lowest, and a final output pass.
// Reset (synchronous, active low) clears control and sets all dimensions to 1;
// element stores hold undefined data until loaded.
module matrix_multiply_power #(
    parameter int MAX_DIM   = mmp_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mmp_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mmp_pkg::CFG_W-1:0]   i_cfg_idx,
    input  logic [mmp_pkg::DIM_W-1:0]   i_cfg_data,
    mmp_in_if.sink                      i_req,
    mmp_out_if.source                   o_res
);

    // The engine is a chain of MAX_DIM identical cells. Cell k owns column k and row k of
    // every stored matrix, so for result element (i,j) it supplies the k-th term of the
    // dot product: it reads X(i,k) and Y(k,j), multiplies, rescales, saturates and adds the
    // term to the partial sum handed on by its left neighbor. Each cell is three register
    // stages deep, and a new element enters every cycle unless the output holds the chain.
    // That rate is set by the single multiplier per cell.
    //
    // Scaling by a 1x1 matrix and the identity are expressed as diagonal operands, so every
    // command runs as passes of the same chain. Power works by repeated squaring into four
    // work buffers; a pass writes into a free buffer so it never overwrites its own operands.
    // Between passes the chain drains before the next pass starts reading.
    //
    // A result that the sink does not take holds the whole chain, so no result is lost.

    localparam int SUM_W = mmp_pkg::VAL_W + $clog2(MAX_DIM) + 1;
    localparam logic [mmp_pkg::DIM_W-1:0] DIM_MAX = (mmp_pkg::DIM_W)'(MAX_DIM);

    logic [mmp_pkg::DIM_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [mmp_pkg::DIM_W-1:0] w_cfg_dim;
    logic [mmp_pkg::VAL_W-1:0] r_a00, r_b00;

    logic w_en, w_ready, w_err, w_accept, w_load_ok;
    mmp_pkg::t_pass w_pass;
    mmp_pkg::t_wr   w_wr;
    mmp_pkg::t_tag  w_tag [MAX_DIM+1];
    logic signed [SUM_W-1:0] w_sum [MAX_DIM+1];
    logic signed [mmp_pkg::VAL_W-1:0] w_end_val;

    logic r_out_valid, r_out_last, r_out_error;
    logic [mmp_pkg::ROW_W-1:0] r_out_row, r_out_col;
    logic [mmp_pkg::VAL_W-1:0] r_out_value;

    // The chain moves whenever the output register is free or being emptied.
    assign w_en     = !r_out_valid || o_res.ready;
    assign w_accept = i_req.valid && w_ready;
    assign i_req.ready = w_ready;

    // Dimension writes are clamped into 1..MAX_DIM.
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_dim = (mmp_pkg::DIM_W)'(1);
        end else if (i_cfg_data > DIM_MAX) begin
            w_cfg_dim = DIM_MAX;
        end else begin
            w_cfg_dim = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= (mmp_pkg::DIM_W)'(1);
            r_a_cols <= (mmp_pkg::DIM_W)'(1);
            r_b_rows <= (mmp_pkg::DIM_W)'(1);
            r_b_cols <= (mmp_pkg::DIM_W)'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mmp_pkg::CFG_A_ROWS: r_a_rows <= w_cfg_dim;
                mmp_pkg::CFG_A_COLS: r_a_cols <= w_cfg_dim;
                mmp_pkg::CFG_B_ROWS: r_b_rows <= w_cfg_dim;
                mmp_pkg::CFG_B_COLS: r_b_cols <= w_cfg_dim;
                default: r_a_rows <= r_a_rows;
            endcase
        end
    end

    // Loads outside the store are dropped.
    assign w_load_ok = ({1'b0, i_req.row} < DIM_MAX) && ({1'b0, i_req.col} < DIM_MAX);

    // The top-left elements are kept aside as scale factors.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_load_ok && i_req.row == '0 && i_req.col == '0) begin
            if (i_req.func == mmp_pkg::FUNC_LOAD_A) begin
                r_a00 <= i_req.value;
            end
            if (i_req.func == mmp_pkg::FUNC_LOAD_B) begin
                r_b00 <= i_req.value;
            end
        end
    end

    mmp_ctrl #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_req.valid),
        .i_func   (i_req.func),
        .i_degree (i_req.degree),
        .i_a_rows (r_a_rows),
        .i_a_cols (r_a_cols),
        .i_b_rows (r_b_rows),
        .i_b_cols (r_b_cols),
        .i_a00    (r_a00),
        .i_b00    (r_b00),
        .o_ready  (w_ready),
        .o_err    (w_err),
        .o_pass   (w_pass),
        .o_tag    (w_tag[0])
    );

    assign w_sum[0] = '0;

    for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
        mmp_cell #(
            .MAX_DIM   (MAX_DIM),
            .FRAC_BITS (FRAC_BITS),
            .CELL_IDX  (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_pass  (w_pass),
            .i_wr    (w_wr),
            .i_tag   (w_tag[k]),
            .i_sum   (w_sum[k]),
            .o_tag   (w_tag[k+1]),
            .o_sum   (w_sum[k+1])
        );
    end

    // The finished dot product saturates to 32 bits.
    always_comb begin
        if ((&w_sum[MAX_DIM][SUM_W-1:mmp_pkg::VAL_W-1]) ||
            (~|w_sum[MAX_DIM][SUM_W-1:mmp_pkg::VAL_W-1])) begin
            w_end_val = w_sum[MAX_DIM][mmp_pkg::VAL_W-1:0];
        end else if (w_sum[MAX_DIM][SUM_W-1]) begin
            w_end_val = {1'b1, {(mmp_pkg::VAL_W-1){1'b0}}};
        end else begin
            w_end_val = {1'b0, {(mmp_pkg::VAL_W-1){1'b1}}};
        end
    end

    // Chain results of intermediate passes go back into a work buffer; loads fill A or B.
    // The two never coincide, since loads are taken only while the chain is empty.
    always_comb begin
        w_wr = '0;
        if (w_en && w_tag[MAX_DIM].valid && !w_pass.emit) begin
            w_wr.en   = 1'b1;
            w_wr.slot = w_pass.dest;
            w_wr.row  = w_tag[MAX_DIM].row;
            w_wr.col  = w_tag[MAX_DIM].col;
            w_wr.data = w_end_val;
        end else if (w_accept && w_load_ok &&
                     (i_req.func == mmp_pkg::FUNC_LOAD_A ||
                      i_req.func == mmp_pkg::FUNC_LOAD_B)) begin
            w_wr.en   = 1'b1;
            w_wr.slot = (i_req.func == mmp_pkg::FUNC_LOAD_A) ? mmp_pkg::SLOT_A
                                                             : mmp_pkg::SLOT_B;
            w_wr.row  = i_req.row;
            w_wr.col  = i_req.col;
            w_wr.data = i_req.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_err || (w_tag[MAX_DIM].valid && w_pass.emit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_err) begin
                r_out_row   <= '0;
                r_out_col   <= '0;
                r_out_value <= '0;
                r_out_last  <= 1'b1;
                r_out_error <= 1'b1;
            end else begin
                r_out_row   <= w_tag[MAX_DIM].row;
                r_out_col   <= w_tag[MAX_DIM].col;
                r_out_value <= w_end_val;
                r_out_last  <= w_tag[MAX_DIM].last;
                r_out_error <= 1'b0;
            end
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_row   = r_out_row;
    assign o_res.out_col   = r_out_col;
    assign o_res.out_value = r_out_value;
    assign o_res.last      = r_out_last;
    assign o_res.error     = r_out_error;

endmodule

FILE: rtl/mmp_cell.sv
module mmp_cell #(
    parameter int MAX_DIM   = mmp_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mmp_pkg::FRAC_BITS_DEF,
    parameter int CELL_IDX  = 0,
    localparam int IDX_W    = $clog2(MAX_DIM),
    localparam int SUM_W    = mmp_pkg::VAL_W + $clog2(MAX_DIM) + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  mmp_pkg::t_pass          i_pass,
    input  mmp_pkg::t_wr            i_wr,
    input  mmp_pkg::t_tag           i_tag,
    input  logic signed [SUM_W-1:0] i_sum,
    output mmp_pkg::t_tag           o_tag,
    output logic signed [SUM_W-1:0] o_sum
);

    localparam logic [mmp_pkg::ROW_W-1:0] K_POS = (mmp_pkg::ROW_W)'(CELL_IDX);
    localparam logic [mmp_pkg::DIM_W-1:0] K_DIM = (mmp_pkg::DIM_W)'(CELL_IDX);

    // Column K and row K of every slot matrix.
    logic [mmp_pkg::VAL_W-1:0] col_mem [mmp_pkg::NUM_SLOTS][MAX_DIM];
    logic [mmp_pkg::VAL_W-1:0] row_mem [mmp_pkg::NUM_SLOTS][MAX_DIM];

    mmp_pkg::t_tag r_t1, r_t2, r_t3;
    logic signed [SUM_W-1:0] r_s1, r_s2, r_s3;
    logic [mmp_pkg::VAL_W-1:0] r_xm, r_ym;
    logic r_xz, r_xv, r_yz, r_yv;
    logic signed [2*mmp_pkg::VAL_W-1:0] r_p;

    logic w_x_zero, w_y_zero;
    logic signed [mmp_pkg::VAL_W-1:0] w_x, w_y, w_term;
    logic signed [2*mmp_pkg::VAL_W-1:0] w_sh;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            if (i_wr.col == K_POS) begin
                col_mem[i_wr.slot][i_wr.row[IDX_W-1:0]] <= i_wr.data;
            end
            if (i_wr.row == K_POS) begin
                row_mem[i_wr.slot][i_wr.col[IDX_W-1:0]] <= i_wr.data;
            end
        end
    end

    always_comb begin
        w_x_zero = (K_DIM >= i_pass.inner) || (i_pass.x_diag && (i_tag.row != K_POS));
        w_y_zero = (K_DIM >= i_pass.inner) || (i_pass.y_diag && (i_tag.col != K_POS));
        w_x = r_xz ? '0 : (r_xv ? i_pass.x_val : r_xm);
        w_y = r_yz ? '0 : (r_yv ? i_pass.y_val : r_ym);
        // Product scaled back by an arithmetic shift, which rounds toward minus infinity.
        w_sh = r_p >>> FRAC_BITS;
        if ((&w_sh[2*mmp_pkg::VAL_W-1:mmp_pkg::VAL_W-1]) ||
            (~|w_sh[2*mmp_pkg::VAL_W-1:mmp_pkg::VAL_W-1])) begin
            w_term = w_sh[mmp_pkg::VAL_W-1:0];
        end else if (w_sh[2*mmp_pkg::VAL_W-1]) begin
            w_term = {1'b1, {(mmp_pkg::VAL_W-1){1'b0}}};
        end else begin
            w_term = {1'b0, {(mmp_pkg::VAL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
        end else if (i_en) begin
            r_t1 <= i_tag;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xm <= col_mem[i_pass.x_slot][i_tag.row[IDX_W-1:0]];
            r_ym <= row_mem[i_pass.y_slot][i_tag.col[IDX_W-1:0]];
            r_xz <= w_x_zero;
            r_yz <= w_y_zero;
            r_xv <= i_pass.x_diag;
            r_yv <= i_pass.y_diag;
            r_s1 <= i_sum;
            r_p  <= w_x * w_y;
            r_s2 <= r_s1;
            r_s3 <= r_s2 + SUM_W'(w_term);
        end
    end

    assign o_tag = r_t3;
    assign o_sum = r_s3;

endmodule

FILE: rtl/mmp_ctrl.sv
module mmp_ctrl #(
    parameter int MAX_DIM   = mmp_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mmp_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [mmp_pkg::FUNC_W-1:0]       i_func,
    input  logic [mmp_pkg::VAL_W-1:0]        i_degree,
    input  logic [mmp_pkg::DIM_W-1:0]        i_a_rows,
    input  logic [mmp_pkg::DIM_W-1:0]        i_a_cols,
    input  logic [mmp_pkg::DIM_W-1:0]        i_b_rows,
    input  logic [mmp_pkg::DIM_W-1:0]        i_b_cols,
    input  logic [mmp_pkg::VAL_W-1:0]        i_a00,
    input  logic [mmp_pkg::VAL_W-1:0]        i_b00,
    output logic                             o_ready,
    output logic                             o_err,
    output mmp_pkg::t_pass                   o_pass,
    output mmp_pkg::t_tag                    o_tag
);

    localparam int DRAIN_N = 3 * MAX_DIM + 3;
    localparam int CNT_W   = $clog2(DRAIN_N + 1);
    localparam logic [mmp_pkg::VAL_W-1:0] ONE = mmp_pkg::VAL_W'(64'd1 << FRAC_BITS);
    localparam logic [mmp_pkg::DIM_W-1:0] DIM_ONE = (mmp_pkg::DIM_W)'(1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PLAN  = 5'b00010,
        S_FEED  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_ERR   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [mmp_pkg::ROW_W-1:0] r_i, n_i, r_j, n_j;
    logic [mmp_pkg::DIM_W-1:0] r_rows, n_rows, r_cols, n_cols;
    mmp_pkg::t_pass r_pass, n_pass;
    mmp_pkg::t_tag  r_tag, n_tag;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [mmp_pkg::VAL_W-1:0] r_mag, n_mag;
    logic [mmp_pkg::SLOT_W-1:0] r_rslot, n_rslot, r_sslot, n_sslot;
    logic r_ident, n_ident, r_bitdone, n_bitdone, r_final, n_final;

    logic [mmp_pkg::SLOT_W-1:0] w_free;
    logic w_row_end, w_col_end;

    // Lowest work buffer that holds neither the running result nor the square.
    always_comb begin
        logic found;
        logic [mmp_pkg::SLOT_W-1:0] cand;
        found  = 1'b0;
        w_free = mmp_pkg::SLOT_WORK0;
        for (int w = 0; w < mmp_pkg::NUM_WORK; w++) begin
            cand = mmp_pkg::SLOT_WORK0 + (mmp_pkg::SLOT_W)'(w);
            if (!found && !(cand == r_rslot && !r_ident) && (cand != r_sslot)) begin
                found  = 1'b1;
                w_free = cand;
            end
        end
    end

    assign w_row_end = ({1'b0, r_i} == r_rows - DIM_ONE);
    assign w_col_end = ({1'b0, r_j} == r_cols - DIM_ONE);

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_rows    = r_rows;
        n_cols    = r_cols;
        n_pass    = r_pass;
        n_tag     = r_tag;
        n_cnt     = r_cnt;
        n_mag     = r_mag;
        n_rslot   = r_rslot;
        n_sslot   = r_sslot;
        n_ident   = r_ident;
        n_bitdone = r_bitdone;
        n_final   = r_final;
        o_ready   = 1'b0;
        o_err     = 1'b0;
        if (i_en) begin
            n_tag.valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                n_i = '0;
                n_j = '0;
                if (i_valid) begin
                    case (i_func)
                        mmp_pkg::FUNC_MUL: begin
                            n_final       = 1'b1;
                            n_pass        = '0;
                            n_pass.emit   = 1'b1;
                            n_pass.x_slot = mmp_pkg::SLOT_A;
                            n_pass.y_slot = mmp_pkg::SLOT_B;
                            n_state       = S_FEED;
                            if (i_a_rows == DIM_ONE && i_a_cols == DIM_ONE) begin
                                // Scale B: diag(a00) times B.
                                n_pass.x_diag = 1'b1;
                                n_pass.x_val  = i_a00;
                                n_pass.inner  = i_b_rows;
                                n_rows        = i_b_rows;
                                n_cols        = i_b_cols;
                            end else if (i_b_rows == DIM_ONE && i_b_cols == DIM_ONE) begin
                                // Scale A: A times diag(b00).
                                n_pass.y_diag = 1'b1;
                                n_pass.y_val  = i_b00;
                                n_pass.inner  = i_a_cols;
                                n_rows        = i_a_rows;
                                n_cols        = i_a_cols;
                            end else if (i_a_cols != i_b_rows) begin
                                n_state = S_ERR;
                            end else begin
                                n_pass.inner = i_a_cols;
                                n_rows       = i_a_rows;
                                n_cols       = i_b_cols;
                            end
                        end
                        mmp_pkg::FUNC_POW: begin
                            if (i_a_rows != i_a_cols) begin
                                n_state = S_ERR;
                            end else begin
                                n_mag     = i_degree[mmp_pkg::VAL_W-1] ?
                                            (mmp_pkg::VAL_W'(0) - i_degree) : i_degree;
                                n_ident   = 1'b1;
                                n_sslot   = mmp_pkg::SLOT_A;
                                n_rslot   = mmp_pkg::SLOT_A;
                                n_bitdone = 1'b0;
                                n_rows    = i_a_rows;
                                n_cols    = i_a_rows;
                                n_state   = S_PLAN;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PLAN: begin
                n_pass       = '0;
                n_pass.inner = r_rows;
                n_i          = '0;
                n_j          = '0;
                if (r_mag == '0) begin
                    // Stream out the running result, times the identity.
                    n_final       = 1'b1;
                    n_pass.emit   = 1'b1;
                    n_pass.y_diag = 1'b1;
                    n_pass.y_val  = ONE;
                    n_pass.x_diag = r_ident;
                    n_pass.x_val  = ONE;
                    n_pass.x_slot = r_rslot;
                    n_state       = S_FEED;
                end else if (r_mag[0] && !r_bitdone) begin
                    n_bitdone = 1'b1;
                    if (r_ident) begin
                        // Identity times the square is the square itself.
                        n_rslot = r_sslot;
                        n_ident = 1'b0;
                    end else begin
                        n_final       = 1'b0;
                        n_pass.x_slot = r_rslot;
                        n_pass.y_slot = r_sslot;
                        n_pass.dest   = w_free;
                        n_rslot       = w_free;
                        n_state       = S_FEED;
                    end
                end else begin
                    n_bitdone = 1'b0;
                    n_mag     = r_mag >> 1;
                    if (r_mag != mmp_pkg::VAL_W'(1)) begin
                        n_final       = 1'b0;
                        n_pass.x_slot = r_sslot;
                        n_pass.y_slot = r_sslot;
                        n_pass.dest   = w_free;
                        n_sslot       = w_free;
                        n_state       = S_FEED;
                    end
                end
            end
            S_FEED: begin
                if (i_en) begin
                    n_tag.valid = 1'b1;
                    n_tag.row   = r_i;
                    n_tag.col   = r_j;
                    n_tag.last  = w_row_end && w_col_end;
                    if (w_col_end) begin
                        n_j = '0;
                        if (w_row_end) begin
                            n_cnt   = CNT_W'(DRAIN_N);
                            n_state = S_DRAIN;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                if (i_en) begin
                    if (r_cnt == '0) begin
                        n_state = r_final ? S_IDLE : S_PLAN;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            S_ERR: begin
                o_err = 1'b1;
                if (i_en) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tag   <= '0;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_tag   <= n_tag;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rows    <= n_rows;
        r_cols    <= n_cols;
        r_pass    <= n_pass;
        r_mag     <= n_mag;
        r_rslot   <= n_rslot;
        r_sslot   <= n_sslot;
        r_ident   <= n_ident;
        r_bitdone <= n_bitdone;
        r_final   <= n_final;
    end

    assign o_pass = r_pass;
    assign o_tag  = r_tag;

endmodule
